FILE: sv/websocket_frame_deframer_macros.svh
// Assertion macros for the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("websocket_frame_deframer: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("websocket_frame_deframer: check failed");

`endif

FILE: sv/wsd_pkg.sv
// Types, codes and helpers for the websocket frame deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PING = 2'd1;
  localparam logic [1:0] KIND_FRAG = 2'd2;
  localparam logic [1:0] KIND_OVER = 2'd3;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_PING = 4'h9;

  localparam logic [31:0] MAX_LEN_RST = 32'd204800;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_data;
    logic [3:0] frame_opcode;
    logic       end_of_frame;
    logic [1:0] frame_kind;
  } res_t;

  function automatic logic [1:0] frame_class(input logic [3:0] opcode, input logic fin);
    logic [1:0] kind;
    if (opcode == OP_PING) begin
      kind = KIND_PING;
    end else if (opcode == OP_CONT || !fin) begin
      kind = KIND_FRAG;
    end else begin
      kind = KIND_DATA;
    end
    return kind;
  endfunction

endpackage

FILE: sv/websocket_frame_deframer.sv
// A result is registered onto out_* from the accepted byte, or into the skid register first while out_* is stalled.
// Throughput: one byte per cycle while in_stall is low; the parser updates in the same edge that takes the byte.
// An output register plus one skid register hold results; in_stall rises only when both are
// full, so bytes keep flowing while one result waits.
// Reset (synchronous, rst_n low): parser back to the first header byte, error cleared,
// both result slots empty, max_frame_len back to 204800.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_data,
  output logic [3:0]  out_frame_opcode,
  output logic        out_end_of_frame,
  output logic [1:0]  out_frame_kind
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] max_len_r;

  logic          out_valid_r, skid_valid_r;
  wsd_pkg::res_t out_r, skid_r;

  logic          acc;
  logic [6:0]    len7;
  logic [63:0]   len_shift, len_cand;
  logic          mask_now, hdr1_short, ext_last, key_last, hdr_done;
  logic          over, zero_len, eof_d;
  logic [1:0]    kind_cur;
  wsd_pkg::phase_t hd_phase;
  logic [7:0]    key_byte;
  logic          res_v;
  wsd_pkg::res_t res;
  logic          out_free;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !in_stall;

  assign len7       = in_rx_byte[6:0];
  assign len_shift  = {len_r[55:0], in_rx_byte};
  assign mask_now   = (phase_r == wsd_pkg::PH_HDR1) ? in_rx_byte[7] : mask_r;
  assign hdr1_short = (phase_r == wsd_pkg::PH_HDR1) && (len7 != wsd_pkg::LEN_EXT16)
                      && (len7 != wsd_pkg::LEN_EXT64);
  assign ext_last   = (phase_r == wsd_pkg::PH_EXT) && (cnt_r >= 3'd7);
  assign key_last   = (phase_r == wsd_pkg::PH_KEY) && (cnt_r >= 3'd3);
  assign hdr_done   = key_last || ((hdr1_short || ext_last) && !mask_now);

  always_comb begin
    case (phase_r)
      wsd_pkg::PH_HDR1: len_cand = {57'd0, len7};
      wsd_pkg::PH_EXT:  len_cand = len_shift;
      default:          len_cand = len_r;
    endcase
  end

  assign over     = len_cand > {32'd0, max_len_r};
  assign zero_len = (len_cand == 64'd0);
  assign hd_phase = over ? wsd_pkg::PH_HALT : (zero_len ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_DATA);
  // len_r counts down the bytes left while in the payload
  assign eof_d    = (len_r <= 64'd1);
  assign kind_cur = wsd_pkg::frame_class(op_r, fin_r);

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    kidx_nxt  = kidx_r;
    key_nxt   = key_r;
    if (acc) begin
      case (phase_r)
        wsd_pkg::PH_HDR0: begin
          fin_nxt   = in_rx_byte[7];
          op_nxt    = in_rx_byte[3:0];
          phase_nxt = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          mask_nxt = in_rx_byte[7];
          key_nxt  = 32'd0;
          len_nxt  = 64'd0;
          if (len7 == wsd_pkg::LEN_EXT16) begin
            cnt_nxt   = 3'd6;
            phase_nxt = wsd_pkg::PH_EXT;
          end else if (len7 == wsd_pkg::LEN_EXT64) begin
            cnt_nxt   = 3'd0;
            phase_nxt = wsd_pkg::PH_EXT;
          end else begin
            len_nxt = len_cand;
            if (mask_now) begin
              cnt_nxt   = 3'd0;
              phase_nxt = wsd_pkg::PH_KEY;
            end else begin
              kidx_nxt  = 2'd0;
              phase_nxt = hd_phase;
            end
          end
        end
        wsd_pkg::PH_EXT: begin
          len_nxt = len_shift;
          if (ext_last) begin
            if (mask_now) begin
              cnt_nxt   = 3'd0;
              phase_nxt = wsd_pkg::PH_KEY;
            end else begin
              kidx_nxt  = 2'd0;
              phase_nxt = hd_phase;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        wsd_pkg::PH_KEY: begin
          key_nxt = {key_r[23:0], in_rx_byte};
          if (key_last) begin
            kidx_nxt  = 2'd0;
            phase_nxt = hd_phase;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        wsd_pkg::PH_DATA: begin
          len_nxt  = len_r - 64'd1;
          kidx_nxt = kidx_r + 2'd1;
          if (eof_d) begin
            phase_nxt = wsd_pkg::PH_HDR0;
          end
        end
        wsd_pkg::PH_HALT: begin
          phase_nxt = wsd_pkg::PH_HALT;
        end
        default: begin
          phase_nxt = wsd_pkg::PH_HALT;
        end
      endcase
    end
  end

  // result for the accepted byte
  always_comb begin
    res_v            = 1'b0;
    res.payload_byte = 8'd0;
    res.has_data     = 1'b0;
    res.frame_opcode = op_r;
    res.end_of_frame = 1'b0;
    res.frame_kind   = wsd_pkg::KIND_DATA;
    if (acc) begin
      if (hdr_done) begin
        res_v            = over || zero_len;
        res.end_of_frame = 1'b1;
        res.frame_kind   = over ? wsd_pkg::KIND_OVER : kind_cur;
      end else if (phase_r == wsd_pkg::PH_DATA) begin
        res.frame_kind = kind_cur;
        if (kind_cur == wsd_pkg::KIND_FRAG) begin
          // fragmented: one end beat only
          res_v            = eof_d;
          res.end_of_frame = 1'b1;
        end else begin
          res_v            = 1'b1;
          res.has_data     = 1'b1;
          res.end_of_frame = eof_d;
          res.payload_byte = in_rx_byte;
          if (kind_cur == wsd_pkg::KIND_DATA && mask_r) begin
            res.payload_byte = in_rx_byte ^ key_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsd_pkg::PH_HDR0;
      fin_r     <= 1'b0;
      op_r      <= 4'd0;
      mask_r    <= 1'b0;
      cnt_r     <= 3'd0;
      len_r     <= 64'd0;
      kidx_r    <= 2'd0;
      key_r     <= 32'd0;
      max_len_r <= wsd_pkg::MAX_LEN_RST;
    end else begin
      phase_r <= phase_nxt;
      fin_r   <= fin_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      kidx_r  <= kidx_nxt;
      key_r   <= key_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_v;
      end
    end else if (res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_has_data     = out_r.has_data;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_end_of_frame = out_r.end_of_frame;
  assign out_frame_kind   = out_r.frame_kind;

endmodule

FILE: sv/wsd_checker.sv
// Port-level checks for the websocket frame deframer, bound to the top level.
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_payload_byte,
  input logic        out_has_data,
  input logic [3:0]  out_frame_opcode,
  input logic        out_end_of_frame,
  input logic [1:0]  out_frame_kind
);

  logic [15:0] out_beat;

  assign out_beat = {out_payload_byte, out_has_data, out_frame_opcode, out_end_of_frame,
                     out_frame_kind};

  // a stalled result beat holds
  `WSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

  `WSD_ASSERT_SAME(a_empty_byte_zero, out_valid && !out_has_data, out_payload_byte == 8'd0)

  // fragmented and oversize kinds only ever close a frame, with no byte
  `WSD_ASSERT_SAME(a_end_only_kinds, out_valid && out_frame_kind[1], out_end_of_frame && !out_has_data)

  // nothing follows the oversize beat
  `WSD_ASSERT_NEXT(a_halt_after_over, out_valid && !out_stall && (out_frame_kind == wsd_pkg::KIND_OVER), !out_valid)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
